// ===== src/kvl_pkg.sv =====
`default_nettype none

package kvl_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_AW   = $clog2(MAX_KEYS);

  localparam int TIME_W   = 32;
  localparam int VAL_W    = 32;
  localparam int WORD_W   = TIME_W + 3 * VAL_W;
  localparam int COUNT_W  = 7;
  localparam int FRAC_W   = 16;

  // restoring divider: step counts for the period wrap and the span fraction
  localparam logic [5:0] DIV_STEPS_MOD  = 6'd33;
  localparam logic [5:0] DIV_STEPS_FRAC = 6'd16;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_ZERO_PERIOD = 2'd1;
  localparam logic [1:0] STATUS_ZERO_SPAN   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRD_RD,
    ST_PRD_CHK,
    ST_MOD,
    ST_SEARCH,
    ST_SPAN,
    ST_FRAC,
    ST_MUL,
    ST_ADD
  } kvl_state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] rem_init;
    logic [32:0] dividend;
    logic [31:0] divisor;
    logic [5:0]  steps;
  } kvl_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
    logic [32:0] quo;
  } kvl_div_rsp_t;

endpackage

`default_nettype wire

// ===== src/kvl_div.sv =====
`default_nettype none

module kvl_div
  import kvl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  kvl_div_req_t req_i,
  output kvl_div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [32:0] dvd_q, dvd_d;
  logic [31:0] dvs_q, dvs_d;

  logic [32:0] shifted;
  logic [32:0] trial;
  logic        ge;

  always_comb begin
    shifted = {rem_q, dvd_q[32]};
    trial   = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // one quotient bit per cycle, shifted in at the bottom of the dividend
      rem_d = ge ? trial[31:0] : shifted[31:0];
      dvd_d = {dvd_q[31:0], ge};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;
  assign rsp_o.quo  = dvd_q;

endmodule

`default_nettype wire

// ===== src/keyframe_vector_lerp.sv =====
// sample: period read and check, wrap divide on the bit-serial divider (33 steps), key
//   search at one table entry per cycle, span check, fraction divide (16 steps) unless the
//   rate is 0 or 1, then multiply and add per axis; an error status ends it at either check
// back-to-back: the next start is taken in the done_o cycle
// load: busy_o stays low; the result strobe cannot be stalled
// reset: control cleared, key_count back to 2, key table contents undefined until written
`default_nettype none

module keyframe_vector_lerp
  import kvl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                start_i,
  output logic                busy_o,
  input  logic                cmd_i,
  input  logic [5:0]          key_index_i,
  input  logic [31:0]         key_time_i,
  input  logic signed [31:0]  key_x_i,
  input  logic signed [31:0]  key_y_i,
  input  logic signed [31:0]  key_z_i,
  input  logic [31:0]         now_time_i,
  input  logic [31:0]         advance_time_i,

  output logic                done_o,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o,
  output logic [1:0]          status_o,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [COUNT_W-1:0]  cfg_data_i
);

  kvl_state_e state_q, state_d;
  logic [COUNT_W-1:0] kc_q, kc_d;
  logic               done_q, done_d;

  logic [32:0]        sum_q, sum_d;
  logic [31:0]        t_q, t_d;
  logic [KEY_AW-1:0]  j_q, j_d;
  logic [WORD_W-1:0]  prev_q, prev_d;
  logic [WORD_W-1:0]  cur_q, cur_d;
  logic [FRAC_W:0]    rate_q, rate_d;
  logic signed [50:0] prod_q, prod_d;
  logic [1:0]         c_q, c_d;
  logic [31:0]        out_x_q, out_x_d;
  logic [31:0]        out_y_q, out_y_d;
  logic [31:0]        out_z_q, out_z_d;
  logic [1:0]         status_q, status_d;

  logic [WORD_W-1:0]  key_mem [MAX_KEYS];
  logic [WORD_W-1:0]  rdata_q;
  logic [KEY_AW-1:0]  raddr;
  logic [KEY_AW-1:0]  waddr;
  logic               mem_we;

  logic               accept;
  logic [KEY_AW-1:0]  last_idx;
  logic [31:0]        rd_time;
  logic signed [32:0] num, den;
  logic [32:0]        an_full, ad_full;
  logic [31:0]        an, ad;
  logic [31:0]        v0, v1, add_res;
  logic signed [32:0] diff;
  logic signed [17:0] rate_s;

  kvl_div_req_t div_req;
  kvl_div_rsp_t div_rsp;

  kvl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign accept      = start_i && (state_q == ST_IDLE);
  assign mem_we      = accept && (cmd_i == CMD_LOAD) && (int'(key_index_i) < MAX_KEYS);
  assign waddr       = KEY_AW'(key_index_i);
  assign rd_time     = rdata_q[WORD_W-1 -: TIME_W];

  // active key count clamped to 2..MAX_KEYS, as the index of the last key
  always_comb begin
    if (kc_q < COUNT_W'(2)) begin
      last_idx = KEY_AW'(1);
    end else if (int'(kc_q) > MAX_KEYS) begin
      last_idx = KEY_AW'(MAX_KEYS - 1);
    end else begin
      last_idx = KEY_AW'(kc_q - COUNT_W'(1));
    end
  end

  always_comb begin
    case (state_q)
      ST_PRD_RD: raddr = last_idx;
      ST_SEARCH: raddr = j_q + KEY_AW'(1);
      default:   raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[waddr] <= {key_time_i, key_x_i, key_y_i, key_z_i};
    end
    rdata_q <= key_mem[raddr];
  end

  // span arithmetic between key s-1 and key s
  always_comb begin
    num     = $signed({1'b0, t_q}) - $signed({1'b0, prev_q[WORD_W-1 -: TIME_W]});
    den     = $signed({1'b0, cur_q[WORD_W-1 -: TIME_W]})
              - $signed({1'b0, prev_q[WORD_W-1 -: TIME_W]});
    an_full = num[32] ? 33'(-num) : 33'(num);
    ad_full = den[32] ? 33'(-den) : 33'(den);
    an      = an_full[31:0];
    ad      = ad_full[31:0];
  end

  always_comb begin
    case (c_q)
      2'd0: begin
        v0 = prev_q[3*VAL_W-1 -: VAL_W];
        v1 = cur_q[3*VAL_W-1 -: VAL_W];
      end
      2'd1: begin
        v0 = prev_q[2*VAL_W-1 -: VAL_W];
        v1 = cur_q[2*VAL_W-1 -: VAL_W];
      end
      default: begin
        v0 = prev_q[VAL_W-1:0];
        v1 = cur_q[VAL_W-1:0];
      end
    endcase
    diff    = $signed({v1[31], v1}) - $signed({v0[31], v0});
    rate_s  = $signed({1'b0, rate_q});
    // floor of product / 2^16 keeps the low 32 bits of the arithmetic shift
    add_res = v0 + prod_q[47:16];
  end

  always_comb begin
    state_d  = state_q;
    kc_d     = kc_q;
    done_d   = 1'b0;
    sum_d    = sum_q;
    t_d      = t_q;
    j_d      = j_q;
    prev_d   = prev_q;
    cur_d    = cur_q;
    rate_d   = rate_q;
    prod_d   = prod_q;
    c_d      = c_q;
    out_x_d  = out_x_q;
    out_y_d  = out_y_q;
    out_z_d  = out_z_q;
    status_d = status_q;

    div_req          = '0;
    div_req.start    = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      kc_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_i == CMD_SAMPLE)) begin
          sum_d   = {1'b0, now_time_i} + {1'b0, advance_time_i};
          state_d = ST_PRD_RD;
        end
      end
      ST_PRD_RD: begin
        state_d = ST_PRD_CHK;
      end
      ST_PRD_CHK: begin
        if (rd_time == '0) begin
          out_x_d  = '0;
          out_y_d  = '0;
          out_z_d  = '0;
          status_d = STATUS_ZERO_PERIOD;
          done_d   = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = '0;
          div_req.dividend = sum_q;
          div_req.divisor  = rd_time;
          div_req.steps    = DIV_STEPS_MOD;
          state_d          = ST_MOD;
        end
      end
      ST_MOD: begin
        if (div_rsp.done) begin
          t_d     = div_rsp.rem;
          j_d     = '0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // rdata_q holds entry j_q, the read of j_q + 1 is in flight
        if (j_q == '0) begin
          prev_d = rdata_q;
          j_d    = j_q + KEY_AW'(1);
        end else if ((t_q < rd_time) || (j_q == last_idx)) begin
          cur_d   = rdata_q;
          state_d = ST_SPAN;
        end else begin
          prev_d = rdata_q;
          j_d    = j_q + KEY_AW'(1);
        end
      end
      ST_SPAN: begin
        c_d = '0;
        if (den == '0) begin
          out_x_d  = '0;
          out_y_d  = '0;
          out_z_d  = '0;
          status_d = STATUS_ZERO_SPAN;
          done_d   = 1'b1;
          state_d  = ST_IDLE;
        end else if ((num == '0) || (num[32] != den[32])) begin
          rate_d  = '0;
          state_d = ST_MUL;
        end else if (an >= ad) begin
          rate_d  = {1'b1, {FRAC_W{1'b0}}};
          state_d = ST_MUL;
        end else begin
          // an < ad, so the quotient fits in the fraction bits
          div_req.start    = 1'b1;
          div_req.rem_init = an;
          div_req.dividend = '0;
          div_req.divisor  = ad;
          div_req.steps    = DIV_STEPS_FRAC;
          state_d          = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (div_rsp.done) begin
          rate_d  = {1'b0, div_rsp.quo[FRAC_W-1:0]};
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = diff * rate_s;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        case (c_q)
          2'd0:    out_x_d = add_res;
          2'd1:    out_y_d = add_res;
          default: out_z_d = add_res;
        endcase
        if (c_q == 2'd2) begin
          status_d = STATUS_OK;
          done_d   = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          c_d     = c_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kc_q    <= COUNT_W'(2);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kc_q    <= kc_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    t_q      <= t_d;
    j_q      <= j_d;
    prev_q   <= prev_d;
    cur_q    <= cur_d;
    rate_q   <= rate_d;
    prod_q   <= prod_d;
    c_q      <= c_d;
    out_x_q  <= out_x_d;
    out_y_q  <= out_y_d;
    out_z_q  <= out_z_d;
    status_q <= status_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  // key_count only changes between samples
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign done_o      = done_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ===== src/kvl_checker.sv =====
`default_nettype none

module kvl_checker
  import kvl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic                cmd_i,
  input logic                done_o,
  input logic signed [31:0]  out_x_o,
  input logic signed [31:0]  out_y_o,
  input logic signed [31:0]  out_z_o,
  input logic [1:0]          status_o
);

  // a load transaction completes at once, a sample transaction occupies the block
  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i == CMD_LOAD)) |=> !busy_o)
    else $error("load transaction left the block busy");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i == CMD_SAMPLE)) |=> busy_o)
    else $error("sample transaction did not occupy the block");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == STATUS_OK) || (status_o == STATUS_ZERO_PERIOD)
                || (status_o == STATUS_ZERO_SPAN)))
    else $error("result carries an undefined status");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STATUS_OK)) |-> ((out_x_o == '0) && (out_y_o == '0)
                                             && (out_z_o == '0)))
    else $error("error result with nonzero values");

endmodule

bind keyframe_vector_lerp kvl_checker u_kvl_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .cmd_i    (cmd_i),
  .done_o   (done_o),
  .out_x_o  (out_x_o),
  .out_y_o  (out_y_o),
  .out_z_o  (out_z_o),
  .status_o (status_o)
);

`default_nettype wire
